// ===== rtl/sted_pkg.sv =====
// shared types, sizes and codes for the sorted timer event queue
// no dependencies; used by every file under rtl
package sted_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_BITS    = $clog2(MAX_RESULTS);

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    localparam logic [2:0] KIND_DONE    = 3'd0;
    localparam logic [2:0] KIND_EXPIRED = 3'd1;
    localparam logic [2:0] KIND_NOTHING = 3'd2;
    localparam logic [2:0] KIND_FULL    = 3'd3;
    localparam logic [2:0] KIND_BADID   = 3'd4;

    typedef logic signed [31:0]     t_time;
    typedef logic [ID_BITS-1:0]     t_id;
    typedef logic [CNT_BITS-1:0]    t_cnt;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] entry_id;
        t_time      time_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_id;
        t_time      out_time;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE,
        OP_POP
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_id      id;
        t_time    due;
    } t_cell_cmd;

    typedef struct packed {
        logic  valid;
        t_id   id;
        t_time due;
    } t_cell_data;

    typedef struct packed {
        t_cell_data head;
        logic       head_due;
        logic       next_due;
        logic       any_match;
        logic       full;
    } t_row_stat;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

// ===== rtl/sted_cell.sv =====
// one slot of the sorted chain: holds an entry, compares it, shifts with its neighbors
// depends on sted_pkg
module sted_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sted_pkg::t_cell_cmd i_cmd,
    input  sted_pkg::t_cell_data i_prev,
    input  logic                i_prev_place,
    input  sted_pkg::t_cell_data i_next,
    input  logic                i_match,
    output sted_pkg::t_cell_data o_data,
    output logic                o_place,
    output logic                o_match,
    output logic                o_gt
);

    logic             r_valid;
    sted_pkg::t_id    r_id;
    sted_pkg::t_time  r_due;
    logic             n_valid;
    sted_pkg::t_id    n_id;
    sted_pkg::t_time  n_due;

    assign o_data.valid = r_valid;
    assign o_data.id    = r_id;
    assign o_data.due   = r_due;

    assign o_gt    = r_valid && (r_due > i_cmd.due);
    assign o_place = !r_valid || o_gt;
    assign o_match = i_match || (r_valid && (r_id == i_cmd.id));

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_due   = r_due;
        case (i_cmd.op)
            sted_pkg::OP_INSERT: begin
                if (o_place) begin
                    if (!i_prev_place) begin
                        n_valid = 1'b1;
                        n_id    = i_cmd.id;
                        n_due   = i_cmd.due;
                    end else begin
                        n_valid = i_prev.valid;
                        n_id    = i_prev.id;
                        n_due   = i_prev.due;
                    end
                end
            end
            sted_pkg::OP_DELETE: begin
                if (o_match) begin
                    n_valid = i_next.valid;
                    n_id    = i_next.id;
                    n_due   = i_next.due;
                end
            end
            sted_pkg::OP_POP: begin
                n_valid = i_next.valid;
                n_id    = i_next.id;
                n_due   = i_next.due;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_id;
        r_due <= n_due;
    end

endmodule

// ===== rtl/sted_ctrl.sv =====
// request register, sequencer and output register of the event queue
// depends on sted_pkg; drives the command seen by every cell
module sted_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  sted_pkg::t_in_item   i_in_item,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output sted_pkg::t_out_item  o_out_item,
    input  logic                 i_out_stall,
    input  sted_pkg::t_row_stat  i_stat,
    output sted_pkg::t_cell_cmd  o_cmd
);

    sted_pkg::t_state    r_state;
    sted_pkg::t_state    n_state;
    sted_pkg::t_in_item  r_req;
    sted_pkg::t_out_item r_out;
    sted_pkg::t_out_item n_out;
    logic                r_out_valid;
    logic                n_out_valid;
    sted_pkg::t_cnt      r_cnt;
    sted_pkg::t_cnt      n_cnt;
    sted_pkg::t_out_item w_res;
    sted_pkg::t_id       w_id;
    logic                w_out_free;

    assign w_id        = sted_pkg::t_id'(r_req.entry_id);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != sted_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state     = r_state;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_cnt       = r_cnt;
        o_cmd.op    = sted_pkg::OP_HOLD;
        o_cmd.id    = w_id;
        o_cmd.due   = r_req.time_value;
        w_res       = '0;
        w_res.last  = 1'b1;
        case (r_req.mode)
            sted_pkg::MODE_INSERT: begin
                w_res.out_id = 8'(w_id);
                if (i_stat.any_match) begin
                    w_res.kind = sted_pkg::KIND_BADID;
                end else if (i_stat.full) begin
                    w_res.kind = sted_pkg::KIND_FULL;
                end else begin
                    w_res.kind = sted_pkg::KIND_DONE;
                end
            end
            sted_pkg::MODE_DELETE: begin
                w_res.out_id = 8'(w_id);
                w_res.kind   = i_stat.any_match ? sted_pkg::KIND_DONE : sted_pkg::KIND_BADID;
            end
            sted_pkg::MODE_TICK: begin
                if (i_stat.head_due) begin
                    w_res.kind     = sted_pkg::KIND_EXPIRED;
                    w_res.out_id   = 8'(i_stat.head.id);
                    w_res.out_time = i_stat.head.due;
                    w_res.last     = (r_cnt == sted_pkg::t_cnt'(sted_pkg::MAX_RESULTS - 1))
                                     || !i_stat.next_due;
                end else begin
                    w_res.kind = sted_pkg::KIND_NOTHING;
                end
            end
            default: begin
                w_res.kind = sted_pkg::KIND_DONE;
            end
        endcase
        case (r_state)
            sted_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = sted_pkg::ST_EXEC;
                end
            end
            sted_pkg::ST_EXEC: begin
                if (w_out_free) begin
                    n_out       = w_res;
                    n_out_valid = 1'b1;
                    case (r_req.mode)
                        sted_pkg::MODE_INSERT: begin
                            if (!i_stat.any_match && !i_stat.full) begin
                                o_cmd.op = sted_pkg::OP_INSERT;
                            end
                        end
                        sted_pkg::MODE_DELETE: begin
                            if (i_stat.any_match) begin
                                o_cmd.op = sted_pkg::OP_DELETE;
                            end
                        end
                        sted_pkg::MODE_TICK: begin
                            if (i_stat.head_due) begin
                                o_cmd.op = sted_pkg::OP_POP;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (w_res.last) begin
                        n_state = sted_pkg::ST_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = sted_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sted_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_state == sted_pkg::ST_IDLE) begin
            r_req <= i_in_item;
        end
    end

endmodule

// ===== rtl/sorted_timer_event_queue.sv =====
// sorted timer event queue: a chain of cells kept in ascending due-time order
// depends on sted_pkg, sted_cell and sted_ctrl
//
// usage:
//   input channel (i_in_valid / o_in_stall / i_in_item) takes one request:
//   insert an id with a due time, delete an id, or tick with the current time.
//   output channel (o_out_valid / i_out_stall / o_out_item) gives the results;
//   last marks the final result of a request.
// timing:
//   a request is taken into the request register and executed from there;
//   each result goes into the output register when that register is free.
//   insert, delete, nothing-due ticks and error results give one result per
//   request. a tick that expires k entries (k up to 16) gives k results, one
//   pop per cycle while the output is not stalled. a new request is taken
//   only when the previous one has written its last result to the output.
// reset:
//   every cell goes empty, the output register empties and the input opens.
// stall:
//   while the output register is full and stalled, execution waits with the
//   queue unchanged; the result register holds its value.
module sorted_timer_event_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  sted_pkg::t_in_item   i_in_item,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output sted_pkg::t_out_item  o_out_item,
    input  logic                 i_out_stall
);

    localparam int D = sted_pkg::QUEUE_DEPTH;

    sted_pkg::t_cell_cmd  w_cmd;
    sted_pkg::t_row_stat  w_stat;
    sted_pkg::t_cell_data w_data  [D];
    logic [D-1:0]         w_place;
    logic [D-1:0]         w_gt;
    logic [D:0]           w_match;
    logic [D-1:0]         w_valid;

    assign w_match[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_cell
            sted_pkg::t_cell_data w_prev;
            sted_pkg::t_cell_data w_next;
            logic                 w_prev_place;

            if (g == 0) begin : g_first
                assign w_prev       = '0;
                assign w_prev_place = 1'b0;
            end else begin : g_mid
                assign w_prev       = w_data[g-1];
                assign w_prev_place = w_place[g-1];
            end

            if (g == D - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_body
                assign w_next = w_data[g+1];
            end

            sted_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_cmd        (w_cmd),
                .i_prev       (w_prev),
                .i_prev_place (w_prev_place),
                .i_next       (w_next),
                .i_match      (w_match[g]),
                .o_data       (w_data[g]),
                .o_place      (w_place[g]),
                .o_match      (w_match[g+1]),
                .o_gt         (w_gt[g])
            );

            assign w_valid[g] = w_data[g].valid;
        end
    endgenerate

    assign w_stat.head      = w_data[0];
    assign w_stat.head_due  = w_data[0].valid && !w_gt[0];
    assign w_stat.next_due  = w_data[1].valid && !w_gt[1];
    assign w_stat.any_match = w_match[D];
    assign w_stat.full      = w_data[D-1].valid;

    sted_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // occupied cells always form a prefix of the chain
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & (w_valid + 1'b1)) == '0)
        else $error("occupied cells are not a prefix");

    // the two front entries stay in ascending order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_data[0].valid && w_data[1].valid) |-> (w_data[0].due <= w_data[1].due))
        else $error("front entries out of order");

    // a taken request closes the input until it is executed
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after a request");

    // reset leaves the output empty
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

// ===== verif/sorted_timer_event_queue_tb.sv =====
`timescale 1ns / 100ps
// testbench for sorted_timer_event_queue: directed and random requests with a scoreboard
// the scoreboard keeps its own sorted copy of the queue and predicts every result
// depends on sted_pkg and the rtl of sorted_timer_event_queue
module sorted_timer_event_queue_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 195;
    localparam int REPORT_LIMIT   = 10;
    localparam int SETTLE_CYCLES  = 24;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    class timer_queue_board;
        sted_pkg::t_id       live_ids[$];
        sted_pkg::t_time     live_dues[$];
        sted_pkg::t_out_item expected_results[$];
        int failures;
        int inserts, deletes, ticks, unused;
        int expired_cnt, full_cnt, badid_cnt, nothing_cnt;

        function int find_slot(sted_pkg::t_id id);
            foreach (live_ids[i])
                if (live_ids[i] == id)
                    return i;
            return -1;
        endfunction

        function void push_result(logic [2:0] kind, logic [7:0] id,
                                  sted_pkg::t_time due, logic last);
            sted_pkg::t_out_item res;
            res.kind = kind;
            res.out_id = id;
            res.out_time = due;
            res.last = last;
            expected_results.push_back(res);
            case (kind)
                sted_pkg::KIND_EXPIRED: expired_cnt++;
                sted_pkg::KIND_FULL:    full_cnt++;
                sted_pkg::KIND_BADID:   badid_cnt++;
                sted_pkg::KIND_NOTHING: nothing_cnt++;
                default: ;
            endcase
        endfunction

        function void note_request(sted_pkg::t_in_item req);
            int pos;
            int k;
            bit more;
            sted_pkg::t_id id;
            sted_pkg::t_time due;
            id = req.entry_id;
            case (req.mode)
                sted_pkg::MODE_INSERT: begin
                    inserts++;
                    if (find_slot(id) >= 0) begin
                        push_result(sted_pkg::KIND_BADID, id, '0, 1'b1);
                    end else if (live_ids.size() >= sted_pkg::QUEUE_DEPTH) begin
                        push_result(sted_pkg::KIND_FULL, id, '0, 1'b1);
                    end else begin
                        pos = live_ids.size();
                        while (pos > 0 && live_dues[pos-1] > req.time_value)
                            pos--;
                        live_ids.insert(pos, id);
                        live_dues.insert(pos, req.time_value);
                        push_result(sted_pkg::KIND_DONE, id, '0, 1'b1);
                    end
                end
                sted_pkg::MODE_DELETE: begin
                    deletes++;
                    pos = find_slot(id);
                    if (pos < 0) begin
                        push_result(sted_pkg::KIND_BADID, id, '0, 1'b1);
                    end else begin
                        live_ids.delete(pos);
                        live_dues.delete(pos);
                        push_result(sted_pkg::KIND_DONE, id, '0, 1'b1);
                    end
                end
                sted_pkg::MODE_TICK: begin
                    ticks++;
                    k = 0;
                    more = live_ids.size() > 0 && live_dues[0] <= req.time_value;
                    if (!more)
                        push_result(sted_pkg::KIND_NOTHING, '0, '0, 1'b1);
                    while (more) begin
                        id = live_ids.pop_front();
                        due = live_dues.pop_front();
                        k++;
                        more = k < sted_pkg::MAX_RESULTS && live_ids.size() > 0
                               && live_dues[0] <= req.time_value;
                        push_result(sted_pkg::KIND_EXPIRED, id, due, !more);
                    end
                end
                default: begin
                    unused++;
                    push_result(sted_pkg::KIND_DONE, '0, '0, 1'b1);
                end
            endcase
        endfunction

        function void report(string what, sted_pkg::t_out_item want,
                             sted_pkg::t_out_item got);
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%0t %s: exp/got kind %0d/%0d id %0d/%0d time %0d/%0d last %0b/%0b",
                         $realtime, what, want.kind, got.kind, want.out_id, got.out_id,
                         want.out_time, got.out_time, want.last, got.last);
        endfunction

        function void check_result(sted_pkg::t_out_item got);
            sted_pkg::t_out_item want;
            if (expected_results.size() == 0) begin
                report("result with nothing expected", '0, got);
                return;
            end
            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.out_id !== want.out_id
                || got.out_time !== want.out_time || got.last !== want.last)
                report("mismatch", want, got);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    sted_pkg::t_in_item  i_in_item;
    logic                o_in_stall;
    logic                o_out_valid;
    sted_pkg::t_out_item o_out_item;
    logic                i_out_stall;

    timer_queue_board board = new;
    int  send_idle_pct = 14;
    int  recv_stall_pct = 68;
    bit  hold_armed = 1'b0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    int  now_time = 0;
    int  burst_left = 0;

    sorted_timer_event_queue dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_item),
        .i_out_stall(i_out_stall)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic sted_pkg::t_in_item make_req(logic [1:0] mode, logic [7:0] id,
                                                    sted_pkg::t_time t);
        sted_pkg::t_in_item req;
        req.mode = mode;
        req.entry_id = id;
        req.time_value = t;
        return req;
    endfunction

    function sted_pkg::t_in_item random_request();
        int pick;
        int sel;
        sted_pkg::t_in_item req;
        pick = $urandom_range(99);
        req.entry_id = 8'($urandom_range(255));
        req.time_value = sted_pkg::t_time'($urandom());
        if (burst_left > 0) begin
            burst_left--;
            pick = 0;
        end else if (pick < 4) begin
            burst_left = $urandom_range(18, 10);
        end
        if (pick < 45) begin
            req.mode = sted_pkg::MODE_INSERT;
            if ($urandom_range(99) < 70)
                req.entry_id = 8'($urandom_range(31));
            if ($urandom_range(99) < 85)
                req.time_value = sted_pkg::t_time'(now_time + int'($urandom_range(300)) - 40);
        end else if (pick < 65) begin
            req.mode = sted_pkg::MODE_DELETE;
            if (board.live_ids.size() > 0 && $urandom_range(99) < 75)
                req.entry_id = board.live_ids[$urandom_range(board.live_ids.size() - 1)];
            else if ($urandom_range(1) == 0)
                req.entry_id = 8'($urandom_range(31));
        end else if (pick < 95) begin
            req.mode = sted_pkg::MODE_TICK;
            now_time += int'($urandom_range(80));
            sel = $urandom_range(99);
            if (sel < 4)
                req.time_value = sted_pkg::t_time'(32'h7fff_ffff);
            else if (sel >= 8)
                req.time_value = sted_pkg::t_time'(now_time);
        end else begin
            req.mode = MODE_UNUSED;
        end
        return req;
    endfunction

    task send(sted_pkg::t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= req;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(req);
    endtask

    task run_directed();
        send(make_req(sted_pkg::MODE_TICK, 8'h5a, '0));
        send(make_req(sted_pkg::MODE_INSERT, 8'h00, sted_pkg::t_time'(32'h8000_0000)));
        send(make_req(sted_pkg::MODE_INSERT, 8'hff, sted_pkg::t_time'(32'h7fff_ffff)));
        send(make_req(sted_pkg::MODE_INSERT, 8'h00, sted_pkg::t_time'(5)));
        send(make_req(sted_pkg::MODE_DELETE, 8'h07, '0));
        send(make_req(MODE_UNUSED, 8'hff, sted_pkg::t_time'(-1)));
        for (int i = 1; i <= 14; i++)
            send(make_req(sted_pkg::MODE_INSERT, 8'(i), '0));
        send(make_req(sted_pkg::MODE_INSERT, 8'd200, sted_pkg::t_time'(-7)));
        send(make_req(sted_pkg::MODE_DELETE, 8'h07, '0));
        send(make_req(sted_pkg::MODE_INSERT, 8'd200, '0));
        send(make_req(sted_pkg::MODE_TICK, 8'h00, sted_pkg::t_time'(32'h7fff_ffff)));
        send(make_req(sted_pkg::MODE_TICK, 8'hff, sted_pkg::t_time'(32'h7fff_ffff)));
    endtask

    // receiver stall, result check and watchdog
    always @(posedge i_clk) begin
        bit next_stall;
        bit took;
        if (hold_armed) begin
            hold_left = HOLD_CYCLES;
            hold_armed = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
        end else begin
            next_stall = $urandom_range(99) < recv_stall_pct;
        end
        i_out_stall <= next_stall;
        if (i_rst_n === 1'b1) begin
            took = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                board.check_result(o_out_item);
                took = 1'b1;
            end
            if (i_in_valid && !o_in_stall)
                took = 1'b1;
            quiet_cycles = took ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, board.pending());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        i_out_stall <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct = 68;
                recv_stall_pct = 14;
            end
            if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
                hold_armed = 1'b1;
            end
            send(random_request());
        end
        i_in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d inserts, %0d deletes, %0d ticks and %0d unused-mode requests",
                 board.inserts, board.deletes, board.ticks, board.unused);
        $display("saw %0d expirations, %0d queue-full, %0d bad-id, %0d nothing-due; %0d errors",
                 board.expired_cnt, board.full_cnt, board.badid_cnt, board.nothing_cnt,
                 board.failures);
        if (board.failures == 0 && board.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sted_pkg.sv
rtl/sted_cell.sv
rtl/sted_ctrl.sv
rtl/sorted_timer_event_queue.sv
verif/sorted_timer_event_queue_tb.sv
